// ----- sv/pem_base64_armor_encoder_defines.svh -----
// Assertion macros shared by the encoder modules.
// They expect signals named clock and reset in the enclosing scope.
`ifndef PEM_BASE64_ARMOR_ENCODER_DEFINES_SVH
`define PEM_BASE64_ARMOR_ENCODER_DEFINES_SVH

`define PEM_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define PEM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pem_pkg.sv -----
`default_nettype none
package pem_pkg;

   localparam int LINE_CHARS = 64;
   localparam int GROUPS_PER_LINE = (LINE_CHARS + 3) / 4;
   localparam int LCG_W = 4;

   localparam int HEAD_LEN = 28;
   localparam int FOOT_LEN = 26;
   localparam logic [8*HEAD_LEN-1:0] HEAD_STR = "-----BEGIN CERTIFICATE-----\n";
   localparam logic [8*FOOT_LEN-1:0] FOOT_STR = "-----END CERTIFICATE-----\n";

   localparam logic [6:0] CHAR_NL = 7'h0A;
   localparam logic [6:0] CHAR_PAD = 7'h3D;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = 2;
   localparam int CMDQ_CNT_W = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       run_last;
      logic       document_end;
   } rsp_type;

   typedef struct packed {
      logic        hdr;
      logic        grp;
      logic [23:0] grp_val;
      logic        grp_nl;
      logic        last;
      logic [1:0]  part_n;
      logic [15:0] part_val;
      logic        tail_nl;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cmdq_stat_type;

   function automatic logic [6:0] b64_char(input logic [5:0] s);
      logic [6:0] r;
      if (s < 6'd26) begin
         r = 7'd65 + {1'b0, s};
      end else if (s < 6'd52) begin
         r = 7'd71 + {1'b0, s};
      end else if (s < 6'd62) begin
         r = {1'b0, s} - 7'd4;
      end else if (s == 6'd62) begin
         r = 7'h2B;
      end else begin
         r = 7'h2F;
      end
      return r;
   endfunction

   function automatic logic [5:0] sextet(input logic [23:0] v, input logic [1:0] i);
      logic [5:0] r;
      case (i)
         2'd0: r = v[23:18];
         2'd1: r = v[17:12];
         2'd2: r = v[11:6];
         default: r = v[5:0];
      endcase
      return r;
   endfunction

   function automatic logic [6:0] head_char(input logic [4:0] idx);
      logic [7:0] c;
      c = HEAD_STR[(HEAD_LEN - 1 - int'(idx)) * 8 +: 8];
      return c[6:0];
   endfunction

   function automatic logic [6:0] foot_char(input logic [4:0] idx);
      logic [7:0] c;
      c = FOOT_STR[(FOOT_LEN - 1 - int'(idx)) * 8 +: 8];
      return c[6:0];
   endfunction

endpackage
`default_nettype wire

// ----- sv/pem_front.sv -----
`default_nettype none
module pem_front
   import pem_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   input  wire cmdq_stat_type q_stat,
   output logic               cmd_push,
   output cmd_type            cmd
);

   logic [15:0]      held_ff, held_in;
   logic [1:0]       phase_ff, phase_in;
   logic [LCG_W-1:0] lcg_ff, lcg_in;
   logic             hdr_sent_ff, hdr_sent_in;
   logic             accept;
   logic [15:0]      held_a;
   logic [1:0]       phase_a;
   logic [LCG_W-1:0] lcg_a;
   logic [LCG_W:0]   lcg_next;

   assign req_ready = !q_stat.full;
   assign accept = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      cmd.hdr = !hdr_sent_ff;
      cmd.last = req_data.last_byte;
      lcg_next = {1'b0, lcg_ff} + {{LCG_W{1'b0}}, 1'b1};
      lcg_a = lcg_ff;
      held_a = held_ff;
      phase_a = phase_ff;
      if (phase_ff >= 2'd2) begin
         cmd.grp = 1'b1;
         cmd.grp_val = {held_ff, req_data.data_byte};
         cmd.grp_nl = (lcg_next >= (LCG_W+1)'(GROUPS_PER_LINE));
         lcg_a = cmd.grp_nl ? '0 : lcg_next[LCG_W-1:0];
         held_a = '0;
         phase_a = 2'd0;
      end else if (phase_ff == 2'd1) begin
         held_a = {held_ff[15:8], req_data.data_byte};
         phase_a = 2'd2;
      end else begin
         held_a = {req_data.data_byte, 8'h00};
         phase_a = 2'd1;
      end
      cmd.part_n = phase_a;
      cmd.part_val = held_a;
      cmd.tail_nl = (phase_a != 2'd0) || (lcg_a != '0);
      cmd_push = accept && (cmd.hdr || cmd.grp || cmd.last);

      held_in = held_ff;
      phase_in = phase_ff;
      lcg_in = lcg_ff;
      hdr_sent_in = hdr_sent_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            held_in = '0;
            phase_in = 2'd0;
            lcg_in = '0;
            hdr_sent_in = 1'b0;
         end else begin
            held_in = held_a;
            phase_in = phase_a;
            lcg_in = lcg_a;
            hdr_sent_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         phase_ff <= 2'd0;
         lcg_ff <= '0;
         hdr_sent_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         phase_ff <= phase_in;
         lcg_ff <= lcg_in;
         hdr_sent_ff <= hdr_sent_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/pem_cmdq.sv -----
`default_nettype none
`include "pem_base64_armor_encoder_defines.svh"
module pem_cmdq
   import pem_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire cmd_type  push_cmd,
   input  wire logic     pop,
   output cmd_type       head,
   output cmdq_stat_type stat
);

   cmd_type               mem_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;

   assign head = mem_ff[rd_ptr_ff];
   assign stat.full = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `PEM_ASSERT_ALWAYS(a_no_push_full, !(push && stat.full), "push into a full queue")
   `PEM_ASSERT_ALWAYS(a_no_pop_empty, !(pop && stat.empty), "pop from an empty queue")
   `PEM_ASSERT_ALWAYS(a_count_bound, count_ff <= CMDQ_CNT_W'(CMDQ_DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

// ----- sv/pem_back.sv -----
`default_nettype none
`include "pem_base64_armor_encoder_defines.svh"
module pem_back
   import pem_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       head,
   input  wire cmdq_stat_type q_stat,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   localparam logic [2:0] SEG_START = 3'd0;
   localparam logic [2:0] SEG_HDR   = 3'd1;
   localparam logic [2:0] SEG_GRP   = 3'd2;
   localparam logic [2:0] SEG_GNL   = 3'd3;
   localparam logic [2:0] SEG_PART  = 3'd4;
   localparam logic [2:0] SEG_TNL   = 3'd5;
   localparam logic [2:0] SEG_FOOT  = 3'd6;
   localparam logic [2:0] SEG_DONE  = 3'd7;

   function automatic logic [2:0] next_seg(input cmd_type c, input logic [2:0] cur);
      logic [2:0] r;
      if (cur < SEG_HDR && c.hdr) begin
         r = SEG_HDR;
      end else if (cur < SEG_GRP && c.grp) begin
         r = SEG_GRP;
      end else if (cur < SEG_GNL && c.grp && c.grp_nl) begin
         r = SEG_GNL;
      end else if (cur < SEG_PART && c.last && c.part_n != 2'd0) begin
         r = SEG_PART;
      end else if (cur < SEG_TNL && c.last && c.tail_nl) begin
         r = SEG_TNL;
      end else if (cur < SEG_FOOT && c.last) begin
         r = SEG_FOOT;
      end else begin
         r = SEG_DONE;
      end
      return r;
   endfunction

   logic [2:0] seg_ff, seg_in;
   logic [4:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] cur_seg;
   logic [2:0] after_seg;
   logic [4:0] last_idx;
   logic       seg_end;
   logic       advance;
   logic [6:0] ch;

   assign cur_seg = (seg_ff == SEG_START) ? next_seg(head, SEG_START) : seg_ff;
   assign after_seg = next_seg(head, cur_seg);
   assign advance = !q_stat.empty && (!valid_ff || rsp_ready);
   assign seg_end = (idx_ff == last_idx);
   assign pop = advance && seg_end && (after_seg == SEG_DONE);
   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      case (cur_seg)
         SEG_HDR: begin
            last_idx = 5'(HEAD_LEN - 1);
            ch = head_char(idx_ff);
         end
         SEG_GRP: begin
            last_idx = 5'd3;
            ch = b64_char(sextet(head.grp_val, idx_ff[1:0]));
         end
         SEG_PART: begin
            last_idx = 5'd3;
            if (idx_ff[1:0] < 2'd2 || (idx_ff[1:0] == 2'd2 && head.part_n > 2'd1)) begin
               ch = b64_char(sextet({head.part_val, 8'h00}, idx_ff[1:0]));
            end else begin
               ch = CHAR_PAD;
            end
         end
         SEG_FOOT: begin
            last_idx = 5'(FOOT_LEN - 1);
            ch = foot_char(idx_ff);
         end
         default: begin
            last_idx = 5'd0;
            ch = CHAR_NL;
         end
      endcase
   end

   always_comb begin
      seg_in = seg_ff;
      idx_in = idx_ff;
      rsp_in = rsp_ff;
      valid_in = valid_ff && !rsp_ready;
      if (advance) begin
         valid_in = 1'b1;
         rsp_in.out_char = ch;
         rsp_in.run_last = seg_end && (after_seg == SEG_DONE);
         rsp_in.document_end = seg_end && (cur_seg == SEG_FOOT);
         if (seg_end) begin
            idx_in = '0;
            seg_in = (after_seg == SEG_DONE) ? SEG_START : after_seg;
         end else begin
            idx_in = idx_ff + 5'd1;
            seg_in = cur_seg;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= SEG_START;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         seg_ff <= seg_in;
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   `PEM_ASSERT_ALWAYS(a_end_is_run_last, !(valid_ff && rsp_ff.document_end) || rsp_ff.run_last, "document end without run end")
   `PEM_ASSERT_NEXT(a_end_restarts, advance && cur_seg == SEG_FOOT && seg_end, seg_ff == SEG_START && idx_ff == 5'd0, "sequencer did not restart after footer")
   `PEM_ASSERT_ALWAYS(a_seg_stored, seg_ff != SEG_DONE, "finished segment code was stored")

endmodule
`default_nettype wire

// ----- sv/pem_base64_armor_encoder.sv -----
`default_nettype none
// PEM armor encoder: takes one binary byte per transaction on req_ and
// streams the base64 PEM text as one 7-bit ASCII character per rsp_
// transaction, with the BEGIN CERTIFICATE line before the first byte of a
// document, a newline after every 64 columns, '=' padding, and the END
// CERTIFICATE line after the byte marked last. The output side produces one
// character per cycle while the command queue is not empty and rsp_ready does
// not hold it back: four characters per three bytes plus one newline per 48
// bytes; the first byte of a document adds the 28-character header and the
// last byte up to 31 characters of padding, line close and footer. A
// four-entry command queue between the input classifier and the character
// sequencer lets input be taken while that text drains.
module pem_base64_armor_encoder
   import pem_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmdq_stat_type q_stat;
   cmd_type       push_cmd;
   cmd_type       head;
   logic          push;
   logic          pop;

   pem_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .cmd_push  (push),
      .cmd       (push_cmd)
   );

   pem_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .stat     (q_stat)
   );

   pem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
